/* rtl/core/lmsm_pkg.sv */
// Shared types and constants for the looping multi-layer sample mixer.
// Holds the command and register codes, the channel beat structs and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package lmsm_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = 16;
   localparam int CLIP_W        = 16;
   localparam int ADDR_IN_W     = 16;
   localparam int CMD_W         = 2;
   localparam int MASK_W        = 4;
   localparam int REG_LAYERS    = 4;
   localparam int REG_IDX_W     = 2;
   localparam int LCOUNT_W      = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 5;
   localparam int FRAC_W        = 28;
   localparam int MIX_LIMIT     = 32767;
   localparam int DEF_LAYERS    = 4;
   localparam int DEF_MEM_DEPTH = 65536;

   // Product widths: sample x layer gain fits 32 signed bits, times master gain 48.
   localparam int PROD1_W = 32;
   localparam int PROD2_W = 48;
   localparam int SUM_W   = 49;
   localparam int QUOT_W  = SUM_W - FRAC_W;

   localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'((64'sd1 <<< FRAC_W) - 64'sd1);
   localparam logic signed [QUOT_W-1:0] QUOT_MAX   = QUOT_W'(MIX_LIMIT);
   localparam logic signed [QUOT_W-1:0] QUOT_MIN   = -QUOT_W'(MIX_LIMIT);

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RENDER  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_LAYER_COUNT  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_LOOP_MASK    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_LENGTHS = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_LAYER_GAINS  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]           command;
      logic [ADDR_IN_W-1:0]       address;
      logic signed [SAMPLE_W-1:0] sample_word;
      logic [GAIN_W-1:0]          master_gain;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic [MASK_W-1:0]          active_mask;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS_RD,
      ST_POS_CHK,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_CLAMP,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/looping_multi_layer_sample_mixer_top.sv */
// Top level of the looping multi-layer sample mixer: sample memory, play position memory,
// layer sequencer, two-stage gain multiply and saturating accumulator.
// Depends on lmsm_pkg.
`timescale 1ns / 1ps

// Usage
// A command beat is taken when start is high and busy is low. A write stores one sample
// word and a restart rewinds all layers; busy stays low for both and no result
// follows. A render mixes one output sample and returns exactly one result beat: rsp_valid
// is high for one cycle with rsp_data, and the receiver must take it then.
// Render steps: each layer in use costs one position memory read and check, and a playing
// layer adds the arithmetic steps (two multiplies, add, round and clamp), its sample memory
// read being issued from the check state. The result strobe follows the last layer. busy is
// high from the cycle after the accept through the strobe cycle, so the next command can be
// taken right after.
// Reset returns the registers to their defaults and rewinds all layers at once through
// the position valid bits; the sample memory keeps whatever it holds, so clips must be
// written before they are played. No clearing pass runs.
// The configuration port is APB style with 64-bit data; register i sits at byte 8*i.

module looping_multi_layer_sample_mixer_top #(
   parameter int LAYERS    = lmsm_pkg::DEF_LAYERS,
   parameter int MEM_DEPTH = lmsm_pkg::DEF_MEM_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lmsm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output lmsm_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lmsm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lmsm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lmsm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int REGION   = MEM_DEPTH / LAYERS;
   localparam int ADDR_W   = $clog2(MEM_DEPTH);
   localparam int CLIP_MAX = (REGION < 65535) ? REGION : 65535;
   localparam int LEN_W    = $clog2(CLIP_MAX + 1);
   localparam int IDX_W    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int USE_MAX  = (LAYERS < lmsm_pkg::REG_LAYERS) ? LAYERS : lmsm_pkg::REG_LAYERS;
   localparam int PENT_W   = LEN_W + 1;

   // Configuration registers.
   logic [lmsm_pkg::LCOUNT_W-1:0]   layer_count_ff;
   logic [lmsm_pkg::MASK_W-1:0]     loop_mask_ff;
   logic [lmsm_pkg::CSR_DATA_W-1:0] clip_lengths_ff;
   logic [lmsm_pkg::CSR_DATA_W-1:0] layer_gains_ff;
   logic                            csr_write;

   // Sequencer.
   lmsm_pkg::state_type             state_ff, state_in;
   logic [lmsm_pkg::REG_IDX_W-1:0]  layer_ff;
   logic [lmsm_pkg::LCOUNT_W-1:0]   n_used;
   logic                            last_layer;
   logic                            accept, accept_render;
   logic                            layer_adv, restart;

   // Memories.
   logic signed [lmsm_pkg::SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
   logic [PENT_W-1:0]                    pos_mem [LAYERS];
   logic [LAYERS-1:0]                    pos_vld_ff;
   logic                                 smem_we, smem_re, pmem_re, pmem_we;
   logic [ADDR_W-1:0]                    smem_raddr;
   logic signed [lmsm_pkg::SAMPLE_W-1:0] smem_rd_ff;
   logic [PENT_W-1:0]                    pmem_rd_ff;
   logic [PENT_W-1:0]                    pmem_wdata;
   logic                                 pvld_q_ff;
   logic [IDX_W-1:0]                     pmem_idx;

   // Per-layer check.
   logic [lmsm_pkg::CLIP_W-1:0]          clip_raw;
   logic [LEN_W-1:0]                     clip_len;
   logic [LEN_W-1:0]                     pos_cur, pos_eff, pos_inc, new_pos;
   logic                                 fin_cur, new_fin, loops, past_end, wraps;
   logic                                 chk_skip, chk_stop, chk_play;
   logic [lmsm_pkg::GAIN_W-1:0]          gain_sel;

   // Arithmetic.
   logic [lmsm_pkg::GAIN_W-1:0]            mg_ff;
   logic signed [lmsm_pkg::PROD1_W-1:0]    prod1_ff, prod1_in;
   logic signed [lmsm_pkg::PROD2_W-1:0]    prod2_ff, prod2_in;
   logic signed [lmsm_pkg::SUM_W-1:0]      sum_ff, sum_in, sum_rnd;
   logic signed [lmsm_pkg::QUOT_W-1:0]     quot, quot_sat;
   logic signed [lmsm_pkg::SAMPLE_W-1:0]   acc_ff;
   logic [lmsm_pkg::MASK_W-1:0]            active_ff;

   //------------------------------------------------------------------
   // Configuration port
   //------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff  <= '0;
         loop_mask_ff    <= '1;
         clip_lengths_ff <= '0;
         layer_gains_ff  <= '0;
      end else if (csr_write) begin
         unique case (paddr[4:3])
            lmsm_pkg::REG_LAYER_COUNT:  layer_count_ff  <= pwdata[lmsm_pkg::LCOUNT_W-1:0];
            lmsm_pkg::REG_LOOP_MASK:    loop_mask_ff    <= pwdata[lmsm_pkg::MASK_W-1:0];
            lmsm_pkg::REG_CLIP_LENGTHS: clip_lengths_ff <= pwdata;
            lmsm_pkg::REG_LAYER_GAINS:  layer_gains_ff  <= pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         lmsm_pkg::REG_LAYER_COUNT:  prdata = lmsm_pkg::CSR_DATA_W'(layer_count_ff);
         lmsm_pkg::REG_LOOP_MASK:    prdata = lmsm_pkg::CSR_DATA_W'(loop_mask_ff);
         lmsm_pkg::REG_CLIP_LENGTHS: prdata = clip_lengths_ff;
         lmsm_pkg::REG_LAYER_GAINS:  prdata = layer_gains_ff;
      endcase
   end

   //------------------------------------------------------------------
   // Layer check: decides skip, stop or play from the position entry
   //------------------------------------------------------------------
   assign n_used = (layer_count_ff > lmsm_pkg::LCOUNT_W'(USE_MAX)) ?
                   lmsm_pkg::LCOUNT_W'(USE_MAX) : layer_count_ff;
   assign last_layer = (lmsm_pkg::LCOUNT_W'(layer_ff) + lmsm_pkg::LCOUNT_W'(1)) >= n_used;
   assign pmem_idx   = IDX_W'(layer_ff);

   always_comb begin
      clip_raw = clip_lengths_ff[lmsm_pkg::CLIP_W*layer_ff +: lmsm_pkg::CLIP_W];
      gain_sel = layer_gains_ff[lmsm_pkg::GAIN_W*layer_ff +: lmsm_pkg::GAIN_W];
      clip_len = (32'(clip_raw) > 32'(CLIP_MAX)) ? LEN_W'(CLIP_MAX) : LEN_W'(clip_raw);
      loops    = loop_mask_ff[layer_ff];
      // An entry not written since reset or restart reads as position 0, not finished.
      pos_cur  = pvld_q_ff ? pmem_rd_ff[LEN_W-1:0] : '0;
      fin_cur  = pvld_q_ff ? pmem_rd_ff[LEN_W] : 1'b0;
      past_end = pos_cur >= clip_len;
      chk_skip = (clip_len == '0) || fin_cur;
      chk_stop = !chk_skip && past_end && !loops;
      chk_play = !chk_skip && !(past_end && !loops);
      pos_eff  = past_end ? '0 : pos_cur;
      pos_inc  = pos_eff + LEN_W'(1);
      wraps    = pos_inc >= clip_len;
      new_pos  = wraps ? '0 : pos_inc;
      new_fin  = wraps && !loops;
      pmem_wdata = chk_stop ? {1'b1, {LEN_W{1'b0}}} : {new_fin, new_pos};
      smem_raddr = ADDR_W'(int'(layer_ff) * REGION) + ADDR_W'(pos_eff);
   end

   //------------------------------------------------------------------
   // Sequencer
   //------------------------------------------------------------------
   assign accept        = start && !busy;
   assign accept_render = accept && (req_data.command == lmsm_pkg::CMD_RENDER);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmsm_pkg::ST_IDLE: begin
            if (accept_render) begin
               state_in = (n_used == '0) ? lmsm_pkg::ST_EMIT : lmsm_pkg::ST_POS_RD;
            end
         end
         lmsm_pkg::ST_POS_RD:  state_in = lmsm_pkg::ST_POS_CHK;
         lmsm_pkg::ST_POS_CHK: begin
            if (chk_play) begin
               state_in = lmsm_pkg::ST_MUL1;
            end else begin
               state_in = last_layer ? lmsm_pkg::ST_EMIT : lmsm_pkg::ST_POS_RD;
            end
         end
         lmsm_pkg::ST_MUL1:  state_in = lmsm_pkg::ST_MUL2;
         lmsm_pkg::ST_MUL2:  state_in = lmsm_pkg::ST_SUM;
         lmsm_pkg::ST_SUM:   state_in = lmsm_pkg::ST_CLAMP;
         lmsm_pkg::ST_CLAMP: state_in = last_layer ? lmsm_pkg::ST_EMIT : lmsm_pkg::ST_POS_RD;
         lmsm_pkg::ST_EMIT:  state_in = lmsm_pkg::ST_IDLE;
         default:            state_in = lmsm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != lmsm_pkg::ST_IDLE);
      rsp_valid = (state_ff == lmsm_pkg::ST_EMIT);
      pmem_re   = (state_ff == lmsm_pkg::ST_POS_RD);
      pmem_we   = (state_ff == lmsm_pkg::ST_POS_CHK) && (chk_stop || chk_play);
      smem_re   = (state_ff == lmsm_pkg::ST_POS_CHK) && chk_play;
      smem_we   = accept && (req_data.command == lmsm_pkg::CMD_WRITE) &&
                  ({16'd0, req_data.address} < 32'(MEM_DEPTH));
      restart   = accept && (req_data.command == lmsm_pkg::CMD_RESTART);
      layer_adv = !last_layer &&
                  (((state_ff == lmsm_pkg::ST_POS_CHK) && !chk_play) ||
                   (state_ff == lmsm_pkg::ST_CLAMP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lmsm_pkg::ST_IDLE;
         layer_ff   <= '0;
         pos_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept_render) begin
            layer_ff <= '0;
         end else if (layer_adv) begin
            layer_ff <= layer_ff + lmsm_pkg::REG_IDX_W'(1);
         end
         if (restart) begin
            pos_vld_ff <= '0;
         end else if (pmem_we) begin
            pos_vld_ff[pmem_idx] <= 1'b1;
         end
      end
   end

   //------------------------------------------------------------------
   // Memories
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (smem_we) begin
         sample_mem[ADDR_W'(req_data.address)] <= req_data.sample_word;
      end
      if (smem_re) begin
         smem_rd_ff <= sample_mem[smem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pmem_we) begin
         pos_mem[pmem_idx] <= pmem_wdata;
      end
      if (pmem_re) begin
         pmem_rd_ff <= pos_mem[pmem_idx];
         pvld_q_ff  <= pos_vld_ff[pmem_idx];
      end
   end

   //------------------------------------------------------------------
   // Gain multiply and saturating accumulate
   //------------------------------------------------------------------
   always_comb begin
      prod1_in = lmsm_pkg::PROD1_W'(smem_rd_ff) *
                 lmsm_pkg::PROD1_W'($signed({1'b0, gain_sel}));
      prod2_in = lmsm_pkg::PROD2_W'(prod1_ff) *
                 lmsm_pkg::PROD2_W'($signed({1'b0, mg_ff}));
      sum_in   = (lmsm_pkg::SUM_W'(acc_ff) <<< lmsm_pkg::FRAC_W) +
                 lmsm_pkg::SUM_W'(prod2_ff);
      // Biasing negative sums makes the arithmetic shift truncate toward zero.
      sum_rnd  = sum_ff + (sum_ff[lmsm_pkg::SUM_W-1] ? lmsm_pkg::ROUND_BIAS : '0);
      quot     = lmsm_pkg::QUOT_W'(sum_rnd >>> lmsm_pkg::FRAC_W);
      if (quot > lmsm_pkg::QUOT_MAX) begin
         quot_sat = lmsm_pkg::QUOT_MAX;
      end else if (quot < lmsm_pkg::QUOT_MIN) begin
         quot_sat = lmsm_pkg::QUOT_MIN;
      end else begin
         quot_sat = quot;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      sum_ff   <= sum_in;
      if (accept_render) begin
         mg_ff     <= req_data.master_gain;
         acc_ff    <= '0;
         active_ff <= '0;
      end else begin
         if (state_ff == lmsm_pkg::ST_CLAMP) begin
            acc_ff <= lmsm_pkg::SAMPLE_W'(quot_sat);
         end
         if (smem_re) begin
            active_ff[layer_ff] <= !new_fin;
         end
      end
   end

   assign rsp_data.mixed_sample = acc_ff;
   assign rsp_data.active_mask  = active_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      accept_render |=> busy)
      else $error("render accepted but block not busy");

   a_mul_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lmsm_pkg::ST_MUL1) |-> $past(smem_re))
      else $error("multiply started without a sample memory read");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mixed_sample != 16'sh8000))
      else $error("mixed sample outside the saturation range");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for looping_multi_layer_sample_mixer_top.
// A scoreboard class follows the layer positions and predicts every mixed sample.
// Depends on lmsm_pkg and the top-level RTL.

class mix_scoreboard;
   localparam int REGION = lmsm_pkg::DEF_MEM_DEPTH / lmsm_pkg::DEF_LAYERS;
   localparam int FRAC   = lmsm_pkg::FRAC_W;

   bit [2:0]          layer_count;
   bit [3:0]          loop_mask;
   bit [63:0]         clip_lengths;
   bit [63:0]         layer_gains;
   bit [15:0]         word_mem [lmsm_pkg::DEF_MEM_DEPTH];
   bit                word_valid [lmsm_pkg::DEF_MEM_DEPTH];
   int unsigned       play_pos [4];
   bit [3:0]          finished;
   lmsm_pkg::rsp_type pending_mixes [$];
   int                fails;

   function new();
      layer_count  = 0;
      loop_mask    = 4'hF;
      clip_lengths = '0;
      layer_gains  = '0;
      finished     = '0;
      fails        = 0;
      foreach (play_pos[i]) play_pos[i] = 0;
   endfunction

   function void write_reg(input logic [lmsm_pkg::REG_IDX_W-1:0] idx, input logic [63:0] value);
      case (idx)
         lmsm_pkg::REG_LAYER_COUNT:  layer_count  = value[2:0];
         lmsm_pkg::REG_LOOP_MASK:    loop_mask    = value[3:0];
         lmsm_pkg::REG_CLIP_LENGTHS: clip_lengths = value;
         lmsm_pkg::REG_LAYER_GAINS:  layer_gains  = value;
         default: ;
      endcase
   endfunction

   // Mixes one output sample. With commit low the layer state is left alone, which lets
   // the stimulus ask which word a render would read before it issues one. Returns the
   // address of the first word that is read but was never written, or -1.
   function int mix_render(input bit [15:0] master, input bit commit,
                           output lmsm_pkg::rsp_type mix);
      longint      acc, sum, lim, smp, lg, mg;
      int unsigned pos, len, n;
      bit          loops, done;
      int          addr;
      bit [3:0]    active;
      acc    = 0;
      active = '0;
      lim    = 64'sd32767 <<< FRAC;
      mg     = master;
      n      = (layer_count > 4) ? 4 : layer_count;
      mix    = '0;
      for (int i = 0; i < n; i++) begin
         len = clip_lengths[16*i +: 16];
         if (len > REGION) len = REGION;
         loops = loop_mask[i];
         pos   = play_pos[i];
         if (len == 0 || finished[i]) continue;
         // The length may have been lowered under a running layer.
         if (pos >= len) begin
            pos = 0;
            if (!loops) begin
               if (commit) begin
                  finished[i] = 1'b1;
                  play_pos[i] = 0;
               end
               continue;
            end
         end
         addr = i * REGION + pos;
         if (!word_valid[addr]) return addr;
         smp = $signed(word_mem[addr]);
         lg  = layer_gains[16*i +: 16];
         sum = acc * (64'sd1 <<< FRAC) + smp * lg * mg;
         if (sum > lim) sum = lim;
         if (sum < -lim) sum = -lim;
         acc = sum / (64'sd1 <<< FRAC);
         pos++;
         done = 1'b0;
         if (pos >= len) begin
            pos  = 0;
            done = !loops;
         end
         if (commit) begin
            play_pos[i] = pos;
            finished[i] = done;
         end
         if (!done) active[i] = 1'b1;
      end
      mix.mixed_sample = acc[15:0];
      mix.active_mask  = active;
      return -1;
   endfunction

   function void note_command(input lmsm_pkg::req_type c);
      lmsm_pkg::rsp_type mix;
      case (c.command)
         lmsm_pkg::CMD_WRITE: begin
            word_mem[c.address]   = c.sample_word;
            word_valid[c.address] = 1'b1;
         end
         lmsm_pkg::CMD_RESTART: begin
            foreach (play_pos[i]) play_pos[i] = 0;
            finished = '0;
         end
         lmsm_pkg::CMD_RENDER: begin
            if (mix_render(c.master_gain, 1'b1, mix) < 0) pending_mixes = {pending_mixes, mix};
         end
         default: ;
      endcase
   endfunction

   function void check_mix(input lmsm_pkg::rsp_type got);
      lmsm_pkg::rsp_type want;
      if (pending_mixes.size() == 0) begin
         fails++;
         $display("%0t: result beat with none expected, got sample %0d mask %b",
                  $time, $signed(got.mixed_sample), got.active_mask);
         return;
      end
      want = pending_mixes.pop_front();
      if (got.mixed_sample !== want.mixed_sample) begin
         fails++;
         $display("%0t: mixed_sample expected %0d got %0d", $time,
                  $signed(want.mixed_sample), $signed(got.mixed_sample));
      end
      if (got.active_mask !== want.active_mask) begin
         fails++;
         $display("%0t: active_mask expected %b got %b", $time,
                  want.active_mask, got.active_mask);
      end
   endfunction
endclass

module testbench;
   import lmsm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int REGION         = DEF_MEM_DEPTH / DEF_LAYERS;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 110;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mix_scoreboard mixes;
   int            stall_cycles;
   int            burst_left;
   bit            quiet;

   looping_multi_layer_sample_mixer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) mixes.check_mix(rsp_data);
         if (start && !busy) mixes.note_command(req_data);
         if (psel && penable && pwrite && pready) mixes.write_reg(paddr[4:3], pwdata);
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_beat(input logic [CMD_W-1:0] cmd, input logic [15:0] addr,
                                         input logic [15:0] word, input logic [15:0] master);
      req_type c;
      c.command     = cmd;
      c.address     = addr;
      c.sample_word = word;
      c.master_gain = master;
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat was taken,
   // with start still high so that a burst runs on without a bubble.
   task automatic send_command(input req_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = quiet ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start      <= 1'b0;
      burst_left = 0;
      while (mixes.pending_mixes.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setup(input logic [2:0] count, input logic [3:0] loops,
                              input logic [63:0] lengths, input logic [63:0] gains);
      wait_idle();
      csr_write(REG_LAYER_COUNT, 64'(count));
      csr_write(REG_LOOP_MASK, 64'(loops));
      csr_write(REG_CLIP_LENGTHS, lengths);
      csr_write(REG_LAYER_GAINS, gains);
   endtask

   // Every word a render is going to read is written first, so no render reads
   // memory that was never written.
   task automatic play_sample(input logic [15:0] master);
      rsp_type dry;
      int      missing;
      missing = mixes.mix_render(master, 1'b0, dry);
      while (missing >= 0) begin
         send_command(make_beat(CMD_WRITE, missing[15:0], pick_word(), 16'($urandom)));
         missing = mixes.mix_render(master, 1'b0, dry);
      end
      send_command(make_beat(CMD_RENDER, 16'($urandom), 16'($urandom), master));
   endtask

   task automatic random_item();
      int          pick;
      logic [15:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         play_sample(pick_gain());
      end else if (pick < 85) begin
         addr = 16'($urandom_range(0, 3) * REGION + $urandom_range(0, 47));
         send_command(make_beat(CMD_WRITE, addr, pick_word(), 16'($urandom)));
      end else if (pick < 92) begin
         send_command(make_beat(CMD_WRITE, 16'($urandom), pick_word(), 16'($urandom)));
      end else if (pick < 97) begin
         send_command(make_beat(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom)));
      end else begin
         send_command(make_beat(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom)));
      end
   endtask

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'($urandom_range(1, 4));
         2, 3: return 16'($urandom_range(5, 40));
         4: return 16'hFFFF;
         5: return 16'($urandom);
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   initial begin
      logic [2:0]  count;
      logic [3:0]  loops;
      logic [63:0] lengths;
      logic [63:0] gains;
      mixes        = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      stall_cycles = 0;
      burst_left   = 0;
      quiet        = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: defaults mix nothing, then the extremes of words, gains and lengths.
      play_sample(16'h4000);
      send_command(make_beat(CMD_UNUSED, 16'hFFFF, 16'h7FFF, 16'hFFFF));
      send_command(make_beat(CMD_WRITE, 16'hFFFF, 16'h8000, 16'h0000));
      send_command(make_beat(CMD_WRITE, 16'h0000, 16'h7FFF, 16'hFFFF));
      send_command(make_beat(CMD_WRITE, 16'h0001, 16'h8000, 16'h0000));
      send_command(make_beat(CMD_WRITE, 16'h4000, 16'h8000, 16'h0000));
      send_command(make_beat(CMD_WRITE, 16'hC000, 16'h7FFF, 16'h0000));
      send_command(make_beat(CMD_WRITE, 16'hC001, 16'hFFFF, 16'h0000));
      // Layer count above four, an empty clip, a clamped length and one looping layer.
      apply_setup(3'd7, 4'b0001, 64'hFFFF_0000_0001_0002, 64'h4000_1234_4000_FFFF);
      play_sample(16'hFFFF);
      play_sample(16'hFFFF);
      play_sample(16'h0000);
      play_sample(16'h4000);
      send_command(make_beat(CMD_RESTART, 16'h0000, 16'h0000, 16'h0000));
      play_sample(16'hFFFF);
      play_sample(16'h0001);
      // Finished layers must stay silent after they are switched to looping.
      wait_idle();
      csr_write(REG_LOOP_MASK, 64'hF);
      play_sample(16'h4000);
      play_sample(16'hFFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: count = 3'd4;
            1: count = 3'd7;
            2: count = 3'd0;
            default: count = 3'($urandom_range(1, 7));
         endcase
         case (phase)
            0: loops = 4'hF;
            1: loops = 4'h0;
            default: loops = 4'($urandom);
         endcase
         for (int i = 0; i < 4; i++) begin
            lengths[16*i +: 16] = pick_length();
            gains[16*i +: 16]   = pick_gain();
         end
         apply_setup(count, loops, lengths, gains);
         quiet = ($urandom_range(0, 3) == 0);
         // Without a restart the old positions carry into the new lengths.
         if ($urandom_range(0, 1) == 0)
            send_command(make_beat(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom)));
         for (int k = 0; k < PHASE_ITEMS; k++) random_item();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mixes.fails == 0 && mixes.pending_mixes.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/lmsm_pkg.sv
rtl/core/looping_multi_layer_sample_mixer_top.sv
verif/testbench.sv
